FILE: rtl/bcflru_pkg.sv
// Shared types and codes for the bounded key/value cache.
// No dependencies; imported by the top level.
package bcflru_pkg;

    localparam int FUNC_W  = 2;
    localparam int LIMIT_W = 5;
    localparam int OCC_W   = 5;
    localparam int CFG_W   = 5;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUT    = 2'd0,
        FN_GET    = 2'd1,
        FN_REMOVE = 2'd2,
        FN_NOP    = 2'd3
    } func_t;

    typedef enum logic {
        CFG_POLICY = 1'b0,
        CFG_LIMIT  = 1'b1
    } cfg_index_t;

    typedef enum logic {
        POL_FIFO = 1'b0,
        POL_LRU  = 1'b1
    } policy_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_PASS,
        ST_WRITE,
        ST_DONE
    } state_t;

endpackage

FILE: rtl/bounded_cache_fifo_lru_replace.sv
// Top level of the bounded fully associative key/value cache.
// Depends on bcflru_pkg and bcflru_ram.
//
// Fully associative key/value cache of SLOTS entries with a configurable entry
// limit and FIFO or LRU replacement. Keys, values and age ranks live in one
// RAM; valid bits live in flops and clear at reset. Every request sweeps the
// RAM once, one entry per cycle, to find the key, the oldest entry and the
// lowest free slot. A request that reorders ages (remove hit, eviction, LRU
// get or put hit) adds a read-modify-write sweep, and an eviction one more
// write for the insert. One request is in flight at a time; the result sits
// in an output register, so the next request is taken while it waits.
// Configuration writes take effect at once and must be made while no request
// is in flight.
module bounded_cache_fifo_lru_replace import bcflru_pkg::*; #(
    parameter int SLOTS      = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [FUNC_W-1:0]     s_func,
    input  logic [KEY_BITS-1:0]   s_key,
    input  logic [VALUE_BITS-1:0] s_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_hit,
    output logic [VALUE_BITS-1:0] m_read_value,
    output logic                  m_evicted,
    output logic [KEY_BITS-1:0]   m_evicted_key,
    output logic [OCC_W-1:0]      m_occupancy
);

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int RANK_W = IDX_W;
    localparam int CNT_W  = IDX_W + 1;
    localparam int WORD_W = RANK_W + KEY_BITS + VALUE_BITS;

    state_t state_reg, state_next;

    logic                  policy_reg, policy_next;
    logic [LIMIT_W-1:0]    limit_reg, limit_next;
    logic [LIMIT_W-1:0]    lim_eff;

    logic [SLOTS-1:0]      valid_reg, valid_next;
    logic [OCC_W-1:0]      count_reg, count_next;

    logic [FUNC_W-1:0]     func_reg, func_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;

    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  chk_reg, chk_next;
    logic [IDX_W-1:0]      chk_idx_reg, chk_idx_next;

    logic                  mt_found_reg, mt_found_next;
    logic [IDX_W-1:0]      mt_idx_reg, mt_idx_next;
    logic [RANK_W-1:0]     mt_rank_reg, mt_rank_next;
    logic [VALUE_BITS-1:0] mt_val_reg, mt_val_next;
    logic                  old_found_reg, old_found_next;
    logic [IDX_W-1:0]      old_idx_reg, old_idx_next;
    logic [KEY_BITS-1:0]   old_key_reg, old_key_next;
    logic                  free_found_reg, free_found_next;
    logic [IDX_W-1:0]      free_idx_reg, free_idx_next;

    logic [RANK_W-1:0]     gap_reg, gap_next;
    logic                  tgt_on_reg, tgt_on_next;
    logic [IDX_W-1:0]      tgt_idx_reg, tgt_idx_next;
    logic [RANK_W-1:0]     tgt_rank_reg, tgt_rank_next;
    logic [VALUE_BITS-1:0] nval_reg, nval_next;
    logic                  ins_on_reg, ins_on_next;
    logic [IDX_W-1:0]      ins_idx_reg, ins_idx_next;
    logic [RANK_W-1:0]     ins_rank_reg, ins_rank_next;

    logic                  res_hit_reg, res_hit_next;
    logic [VALUE_BITS-1:0] res_rd_reg, res_rd_next;
    logic                  res_ev_reg, res_ev_next;
    logic [KEY_BITS-1:0]   res_evk_reg, res_evk_next;

    logic                  m_valid_reg, m_valid_next;
    logic                  m_hit_reg, m_hit_next;
    logic [VALUE_BITS-1:0] m_rd_reg, m_rd_next;
    logic                  m_ev_reg, m_ev_next;
    logic [KEY_BITS-1:0]   m_evk_reg, m_evk_next;
    logic [OCC_W-1:0]      m_occ_reg, m_occ_next;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [WORD_W-1:0]     ram_wdata;
    logic [IDX_W-1:0]      ram_raddr;
    logic [WORD_W-1:0]     ram_rdata;

    logic [RANK_W-1:0]     rd_rank;
    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_val;
    logic                  chk_valid;
    logic                  issue;
    logic                  chk_last;

    bcflru_ram #(
        .WIDTH(WORD_W),
        .DEPTH(SLOTS)
    ) u_ram (
        .clk  (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign rd_rank   = ram_rdata[WORD_W-1 -: RANK_W];
    assign rd_key    = ram_rdata[KEY_BITS+VALUE_BITS-1 -: KEY_BITS];
    assign rd_val    = ram_rdata[VALUE_BITS-1:0];
    assign chk_valid = valid_reg[chk_idx_reg];
    assign issue     = (cnt_reg < CNT_W'(SLOTS));
    assign chk_last  = chk_reg && (chk_idx_reg == IDX_W'(SLOTS - 1));

    always_comb begin
        if (limit_reg == '0) begin
            lim_eff = LIMIT_W'(1);
        end else if (32'(limit_reg) > SLOTS) begin
            lim_eff = LIMIT_W'(SLOTS);
        end else begin
            lim_eff = limit_reg;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next      = state_reg;
        policy_next     = policy_reg;
        limit_next      = limit_reg;
        valid_next      = valid_reg;
        count_next      = count_reg;
        func_next       = func_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        cnt_next        = cnt_reg;
        chk_next        = 1'b0;
        chk_idx_next    = cnt_reg[IDX_W-1:0];
        mt_found_next   = mt_found_reg;
        mt_idx_next     = mt_idx_reg;
        mt_rank_next    = mt_rank_reg;
        mt_val_next     = mt_val_reg;
        old_found_next  = old_found_reg;
        old_idx_next    = old_idx_reg;
        old_key_next    = old_key_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        gap_next        = gap_reg;
        tgt_on_next     = tgt_on_reg;
        tgt_idx_next    = tgt_idx_reg;
        tgt_rank_next   = tgt_rank_reg;
        nval_next       = nval_reg;
        ins_on_next     = ins_on_reg;
        ins_idx_next    = ins_idx_reg;
        ins_rank_next   = ins_rank_reg;
        res_hit_next    = res_hit_reg;
        res_rd_next     = res_rd_reg;
        res_ev_next     = res_ev_reg;
        res_evk_next    = res_evk_reg;
        m_valid_next    = m_valid_reg;
        m_hit_next      = m_hit_reg;
        m_rd_next       = m_rd_reg;
        m_ev_next       = m_ev_reg;
        m_evk_next      = m_evk_reg;
        m_occ_next      = m_occ_reg;
        ram_we          = 1'b0;
        ram_waddr       = chk_idx_reg;
        ram_wdata       = ram_rdata;
        ram_raddr       = cnt_reg[IDX_W-1:0];

        if (cfg_we) begin
            case (cfg_index)
                CFG_POLICY: policy_next = cfg_wdata[0];
                CFG_LIMIT:  limit_next  = cfg_wdata[LIMIT_W-1:0];
                default:    policy_next = policy_reg;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    func_next       = s_func;
                    key_next        = s_key;
                    val_next        = s_value;
                    cnt_next        = '0;
                    mt_found_next   = 1'b0;
                    old_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (issue) begin
                    chk_next = 1'b1;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                if (chk_reg) begin
                    if (chk_valid && rd_key == key_reg) begin
                        mt_found_next = 1'b1;
                        mt_idx_next   = chk_idx_reg;
                        mt_rank_next  = rd_rank;
                        mt_val_next   = rd_val;
                    end
                    if (chk_valid && rd_rank == '0) begin
                        old_found_next = 1'b1;
                        old_idx_next   = chk_idx_reg;
                        old_key_next   = rd_key;
                    end
                    if (!chk_valid && !free_found_reg) begin
                        free_found_next = 1'b1;
                        free_idx_next   = chk_idx_reg;
                    end
                end
                if (chk_last) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                res_hit_next = 1'b0;
                res_rd_next  = '0;
                res_ev_next  = 1'b0;
                res_evk_next = '0;
                tgt_on_next  = 1'b0;
                ins_on_next  = 1'b0;
                nval_next    = val_reg;
                cnt_next     = '0;
                state_next   = ST_DONE;
                case (func_reg)
                    FN_PUT: begin
                        if (mt_found_reg) begin
                            res_hit_next = 1'b1;
                            if (policy_reg == POL_LRU) begin
                                tgt_on_next   = 1'b1;
                                tgt_idx_next  = mt_idx_reg;
                                tgt_rank_next = RANK_W'(count_reg - OCC_W'(1));
                                gap_next      = mt_rank_reg;
                                state_next    = ST_PASS;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = mt_idx_reg;
                                ram_wdata = {mt_rank_reg, key_reg, val_reg};
                            end
                        end else if (count_reg >= lim_eff && old_found_reg) begin
                            res_ev_next              = 1'b1;
                            res_evk_next             = old_key_reg;
                            valid_next[old_idx_reg]  = 1'b0;
                            gap_next                 = '0;
                            ins_on_next              = 1'b1;
                            ins_rank_next = RANK_W'(count_reg - OCC_W'(1));
                            if (free_found_reg && free_idx_reg < old_idx_reg) begin
                                ins_idx_next = free_idx_reg;
                            end else begin
                                ins_idx_next = old_idx_reg;
                            end
                            state_next = ST_PASS;
                        end else if (free_found_reg) begin
                            ram_we                   = 1'b1;
                            ram_waddr                = free_idx_reg;
                            ram_wdata = {RANK_W'(count_reg), key_reg, val_reg};
                            valid_next[free_idx_reg] = 1'b1;
                            count_next               = count_reg + OCC_W'(1);
                        end
                    end
                    FN_GET: begin
                        if (mt_found_reg) begin
                            res_hit_next = 1'b1;
                            res_rd_next  = mt_val_reg;
                            if (policy_reg == POL_LRU) begin
                                tgt_on_next   = 1'b1;
                                tgt_idx_next  = mt_idx_reg;
                                tgt_rank_next = RANK_W'(count_reg - OCC_W'(1));
                                nval_next     = mt_val_reg;
                                gap_next      = mt_rank_reg;
                                state_next    = ST_PASS;
                            end
                        end
                    end
                    FN_REMOVE: begin
                        if (mt_found_reg) begin
                            res_hit_next           = 1'b1;
                            valid_next[mt_idx_reg] = 1'b0;
                            count_next             = count_reg - OCC_W'(1);
                            gap_next               = mt_rank_reg;
                            state_next             = ST_PASS;
                        end
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_PASS: begin
                if (issue) begin
                    chk_next = 1'b1;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                if (chk_reg) begin
                    if (tgt_on_reg && chk_idx_reg == tgt_idx_reg) begin
                        ram_we    = 1'b1;
                        ram_wdata = {tgt_rank_reg, rd_key, nval_reg};
                    end else if (chk_valid && rd_rank > gap_reg) begin
                        ram_we    = 1'b1;
                        ram_wdata = {rd_rank - RANK_W'(1), rd_key, rd_val};
                    end
                end
                if (chk_last) begin
                    state_next = ins_on_reg ? ST_WRITE : ST_DONE;
                end
            end
            ST_WRITE: begin
                ram_we                  = 1'b1;
                ram_waddr               = ins_idx_reg;
                ram_wdata               = {ins_rank_reg, key_reg, val_reg};
                valid_next[ins_idx_reg] = 1'b1;
                state_next              = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_hit_next   = res_hit_reg;
                    m_rd_next    = res_rd_reg;
                    m_ev_next    = res_ev_reg;
                    m_evk_next   = res_evk_reg;
                    m_occ_next   = count_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            policy_reg  <= POL_FIFO;
            limit_reg   <= LIMIT_W'(16);
            valid_reg   <= '0;
            count_reg   <= '0;
            cnt_reg     <= '0;
            chk_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            policy_reg  <= policy_next;
            limit_reg   <= limit_next;
            valid_reg   <= valid_next;
            count_reg   <= count_next;
            cnt_reg     <= cnt_next;
            chk_reg     <= chk_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg       <= func_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        chk_idx_reg    <= chk_idx_next;
        mt_found_reg   <= mt_found_next;
        mt_idx_reg     <= mt_idx_next;
        mt_rank_reg    <= mt_rank_next;
        mt_val_reg     <= mt_val_next;
        old_found_reg  <= old_found_next;
        old_idx_reg    <= old_idx_next;
        old_key_reg    <= old_key_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        gap_reg        <= gap_next;
        tgt_on_reg     <= tgt_on_next;
        tgt_idx_reg    <= tgt_idx_next;
        tgt_rank_reg   <= tgt_rank_next;
        nval_reg       <= nval_next;
        ins_on_reg     <= ins_on_next;
        ins_idx_reg    <= ins_idx_next;
        ins_rank_reg   <= ins_rank_next;
        res_hit_reg    <= res_hit_next;
        res_rd_reg     <= res_rd_next;
        res_ev_reg     <= res_ev_next;
        res_evk_reg    <= res_evk_next;
        m_hit_reg      <= m_hit_next;
        m_rd_reg       <= m_rd_next;
        m_ev_reg       <= m_ev_next;
        m_evk_reg      <= m_evk_next;
        m_occ_reg      <= m_occ_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_hit         = m_hit_reg;
    assign m_read_value  = m_rd_reg;
    assign m_evicted     = m_ev_reg;
    assign m_evicted_key = m_evk_reg;
    assign m_occupancy   = m_occ_reg;

endmodule

FILE: rtl/bcflru_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bcflru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/bcflru_checker.sv
// Port-level checks for the bounded key/value cache, bound to its top level.
// Depends on bcflru_pkg and bounded_cache_fifo_lru_replace.
module bcflru_assertions import bcflru_pkg::*; #(
    parameter int SLOTS      = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic                  m_hit,
    input logic [VALUE_BITS-1:0] m_read_value,
    input logic                  m_evicted,
    input logic [KEY_BITS-1:0]   m_evicted_key,
    input logic [OCC_W-1:0]      m_occupancy
);

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit) && $stable(m_read_value)
            && $stable(m_evicted) && $stable(m_evicted_key) && $stable(m_occupancy))
        else $error("result changed while stalled");

    a_evict_on_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_evicted |-> !m_hit && m_occupancy != '0)
        else $error("eviction reported on a hit or an empty cache");

    a_evict_key_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_evicted |-> m_evicted_key == '0)
        else $error("evicted key set without an eviction");

    a_value_on_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_read_value != '0 |-> m_hit && !m_evicted)
        else $error("read value set without a get hit");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready && (!m_valid || m_occupancy <= SLOTS))
        else $error("second request taken while one is in flight");

endmodule

bind bounded_cache_fifo_lru_replace bcflru_assertions #(
    .SLOTS     (SLOTS),
    .KEY_BITS  (KEY_BITS),
    .VALUE_BITS(VALUE_BITS)
) u_bcflru_assertions (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_hit        (m_hit),
    .m_read_value (m_read_value),
    .m_evicted    (m_evicted),
    .m_evicted_key(m_evicted_key),
    .m_occupancy  (m_occupancy)
);
